// ===== sv/clpe_pkg.sv =====
package clpe_pkg;

  localparam int DEF_NUM_CHANNELS = 8;
  localparam int DEF_SAMPLE_MAX   = 4095;
  localparam int DEF_FULL_SCALE   = 1000;

  localparam int POS_SCALE = 1000;
  localparam int WSUM_W    = 26;
  localparam int VSUM_W    = 13;
  localparam int POS_W     = 13;
  localparam int LEVEL_W   = 10;
  localparam int SAMPLE_W  = 12;
  localparam int CH_W      = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;
  // divider operand width: covers 4095*1000 numerator and the 26-bit weighted sum
  localparam int DIV_W     = 26;
  localparam int DIV_CNT_W = 5;

  localparam logic [1:0] ACT_MEASURE   = 2'd0;
  localparam logic [1:0] ACT_CALIBRATE = 2'd1;
  localparam logic [1:0] ACT_CLEAR     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_DETECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTRIBUTE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_LEFT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_RIGHT  = 2'd3;

  localparam logic KIND_POSITION  = 1'b0;
  localparam logic KIND_THRESHOLD = 1'b1;

  typedef struct packed {
    logic [1:0]          action;
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } in_item_t;

  typedef struct packed {
    logic                kind;
    logic [POS_W-1:0]    position;
    logic                line_found;
    logic [SAMPLE_W-1:0] threshold;
    logic [CH_W-1:0]     channel_out;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_NORM_DIV,
    ST_ACCUM,
    ST_POS_DIV,
    ST_FINISH,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic norm_start;
    logic accum;
    logic pos_start;
    logic finish;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic is_measure;
    logic is_cal_result;
    logic last;
    logic need_div;
    logic pos_needed;
  } dp_status_t;

endpackage

// ===== sv/clpe_divider.sv =====
module clpe_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [clpe_pkg::DIV_W-1:0]  dividend,
  input  logic [clpe_pkg::DIV_W-1:0]  divisor,
  output logic                        done,
  output logic [clpe_pkg::DIV_W-1:0]  quotient
);
  import clpe_pkg::*;

  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] count;
  logic                 busy;
  logic [DIV_W:0]       trial;

  assign trial    = {rem[DIV_W-2:0], quo[DIV_W-1]} - {1'b0, dvs};
  assign quotient = quo;

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy) begin
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[DIV_W]) begin
        rem <= trial[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DIV_W-2:0], quo[DIV_W-1]};
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== sv/clpe_datapath.sv =====
module clpe_datapath #(
  parameter int NUM_CHANNELS = clpe_pkg::DEF_NUM_CHANNELS,
  parameter int SAMPLE_MAX   = clpe_pkg::DEF_SAMPLE_MAX,
  parameter int FULL_SCALE   = clpe_pkg::DEF_FULL_SCALE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  clpe_pkg::in_item_t            in_item,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [clpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clpe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  clpe_pkg::dp_cmd_t             cmd,
  output clpe_pkg::dp_status_t          status,
  output clpe_pkg::out_item_t           out_item
);
  import clpe_pkg::*;

  localparam logic [POS_W-1:0] RIGHT_END = POS_W'((NUM_CHANNELS - 1) * POS_SCALE);
  localparam logic [SAMPLE_W-1:0] SMAX = SAMPLE_W'(SAMPLE_MAX);

  logic [LEVEL_W-1:0] line_detect_level, contribute_level;
  logic [POS_W-1:0]   lost_left_limit, lost_right_limit;

  logic [SAMPLE_W-1:0] cal_low  [NUM_CHANNELS];
  logic [SAMPLE_W-1:0] cal_high [NUM_CHANNELS];
  logic                cal_written [NUM_CHANNELS];
  logic                cleared;

  logic [WSUM_W-1:0] weighted_sum;
  logic [VSUM_W-1:0] value_sum;
  logic              line_seen;
  logic [POS_W-1:0]  previous_position;

  in_item_t            item;
  logic [SAMPLE_W-1:0] samp;
  logic                ch_ok;
  logic                neg_num, equal, neg_den;
  logic [SAMPLE_W:0]   num_mag, den_mag;
  logic [WSUM_W-1:0]   num_scaled;
  logic [LEVEL_W-1:0]  norm;
  logic [CH_W-1:0]     ch_idx;

  logic                div_start, div_done;
  logic [DIV_W-1:0]    div_a, div_b, div_q;

  logic [SAMPLE_W-1:0] cur_lo, cur_hi;
  logic [LEVEL_W-1:0]  norm_next;
  logic [WSUM_W+1:0]   wsum_add;
  logic [VSUM_W:0]     vsum_add;
  logic [WSUM_W-1:0]   prod;
  logic [POS_W-1:0]    pos_fb;
  logic [SAMPLE_W:0]   mid_sum;
  logic [SAMPLE_W-1:0] new_lo, new_hi;
  logic [SAMPLE_W-1:0] mid_hold;

  assign ch_idx = CH_W'(item.channel);
  assign cur_lo = cleared ? SMAX : (cal_written[ch_idx] ? cal_low[ch_idx]  : SAMPLE_W'(500));
  assign cur_hi = cleared ? '0   : (cal_written[ch_idx] ? cal_high[ch_idx] : SAMPLE_W'(3500));

  always_ff @(posedge clk) begin
    if (rst) begin
      line_detect_level <= LEVEL_W'(200);
      contribute_level  <= LEVEL_W'(50);
      lost_left_limit   <= POS_W'(2000);
      lost_right_limit  <= POS_W'(5000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LINE_DETECT: line_detect_level <= cfg_data[LEVEL_W-1:0];
        REG_CONTRIBUTE:  contribute_level  <= cfg_data[LEVEL_W-1:0];
        REG_LOST_LEFT:   lost_left_limit   <= cfg_data[POS_W-1:0];
        REG_LOST_RIGHT:  lost_right_limit  <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_item;
      samp <= (in_item.sample > SMAX) ? SMAX : in_item.sample;
    end
  end

  assign ch_ok = 32'(item.channel) < NUM_CHANNELS;

  assign num_mag = (samp >= cur_lo) ? {1'b0, samp - cur_lo} : {1'b0, cur_lo - samp};
  assign den_mag = (cur_hi >= cur_lo) ? {1'b0, cur_hi - cur_lo} : {1'b0, cur_lo - cur_hi};

  // latch operand signs for the quotient fix-up
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      equal   <= cur_hi == cur_lo;
      neg_den <= cur_hi < cur_lo;
      neg_num <= samp < cur_lo;
    end
  end

  assign num_scaled = WSUM_W'(num_mag * FULL_SCALE);
  assign div_start  = cmd.norm_start || cmd.pos_start;
  assign div_a      = cmd.pos_start ? weighted_sum : num_scaled;
  assign div_b      = cmd.pos_start ? DIV_W'(value_sum) : DIV_W'(den_mag);

  clpe_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // equal bounds or a negative quotient (signs differ, nonzero) give zero; above full scale clamps to full scale
  always_comb begin
    if (equal || (neg_num != neg_den && div_q != '0)) begin
      norm_next = '0;
    end else if (div_q > DIV_W'(FULL_SCALE)) begin
      norm_next = LEVEL_W'(FULL_SCALE);
    end else begin
      norm_next = div_q[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) norm <= norm_next;
  end

  assign prod     = WSUM_W'(norm * (POS_SCALE * 32'(item.channel)));
  assign wsum_add = (WSUM_W+2)'(weighted_sum) + (WSUM_W+2)'(prod);
  assign vsum_add = (VSUM_W+1)'(value_sum) + (VSUM_W+1)'(norm);

  always_comb begin
    if (previous_position < lost_left_limit) pos_fb = '0;
    else if (previous_position > lost_right_limit) pos_fb = RIGHT_END;
    else pos_fb = previous_position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weighted_sum      <= '0;
      value_sum         <= '0;
      line_seen         <= 1'b0;
      previous_position <= POS_W'(3500);
    end else if (cmd.accum) begin
      if (norm > line_detect_level) line_seen <= 1'b1;
      if (norm > contribute_level) begin
        weighted_sum <= wsum_add[WSUM_W+1:WSUM_W] != '0 ? '1 : wsum_add[WSUM_W-1:0];
        value_sum    <= vsum_add[VSUM_W] ? '1 : vsum_add[VSUM_W-1:0];
      end
    end else if (cmd.finish) begin
      weighted_sum <= '0;
      value_sum    <= '0;
      line_seen    <= 1'b0;
      if (status.pos_needed) begin
        previous_position <= (div_q > DIV_W'(RIGHT_END)) ? RIGHT_END : div_q[POS_W-1:0];
      end
    end
  end

  assign new_lo  = (samp < cur_lo) ? samp : cur_lo;
  assign new_hi  = (samp > cur_hi) ? samp : cur_hi;
  assign mid_sum = (SAMPLE_W+1)'(new_lo) + (SAMPLE_W+1)'(new_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      cleared <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) cal_written[i] <= 1'b0;
    end else if (cmd.load && item.action == ACT_CLEAR) begin
      cleared <= 1'b1;
      for (int i = 0; i < NUM_CHANNELS; i++) cal_written[i] <= 1'b0;
    end else if (cmd.load && item.action == ACT_CALIBRATE && ch_ok) begin
      cal_written[ch_idx] <= 1'b1;
      if (cleared) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (!cal_written[i] && i != 32'(ch_idx)) cal_written[i] <= 1'b1;
        end
      end
      cleared <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && item.action == ACT_CALIBRATE && ch_ok) begin
      // other channels keep the cleared value until written
      if (cleared) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (!cal_written[i] && i != 32'(ch_idx)) begin
            cal_low[i]  <= SMAX;
            cal_high[i] <= '0;
          end
        end
      end
      cal_low[ch_idx]  <= new_lo;
      cal_high[ch_idx] <= new_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) mid_hold <= mid_sum[SAMPLE_W:1];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (status.is_cal_result) begin
        out_item <= '{kind: KIND_THRESHOLD, position: '0, line_found: 1'b0,
                      threshold: mid_hold, channel_out: item.channel};
      end else if (status.pos_needed) begin
        out_item <= '{kind: KIND_POSITION,
                      position: (div_q > DIV_W'(RIGHT_END)) ? RIGHT_END : div_q[POS_W-1:0],
                      line_found: 1'b1, threshold: '0, channel_out: '0};
      end else begin
        out_item <= '{kind: KIND_POSITION, position: pos_fb, line_found: 1'b0,
                      threshold: '0, channel_out: '0};
      end
    end
  end

  assign status.div_done      = div_done;
  assign status.is_measure    = item.action == ACT_MEASURE;
  assign status.is_cal_result = item.action == ACT_CALIBRATE && ch_ok;
  assign status.last          = item.last;
  assign status.need_div      = ch_ok && (cur_hi != cur_lo);
  assign status.pos_needed    = line_seen && value_sum != '0;
endmodule

// ===== sv/clpe_ctrl.sv =====
module clpe_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  clpe_pkg::dp_status_t status,
  output clpe_pkg::dp_cmd_t    cmd
);
  import clpe_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_LOAD;
      ST_LOAD: begin
        if (status.is_cal_result) state_next = ST_EMIT;
        else if (!status.is_measure) state_next = ST_IDLE;
        else if (status.need_div) state_next = ST_NORM_DIV;
        else if (status.last) state_next = ST_FINISH;
        else state_next = ST_IDLE;
      end
      ST_NORM_DIV: if (status.div_done) state_next = ST_ACCUM;
      ST_ACCUM:    state_next = !status.last ? ST_IDLE : ST_FINISH;
      ST_FINISH:   state_next = status.pos_needed ? ST_POS_DIV : ST_EMIT;
      ST_POS_DIV:  if (status.div_done) state_next = ST_EMIT;
      ST_EMIT:     if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_stall       = state != ST_IDLE;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      ST_IDLE:     cmd.capture = in_valid;
      ST_LOAD: begin
        cmd.load       = 1'b1;
        cmd.norm_start = status.is_measure && status.need_div;
      end
      ST_NORM_DIV: ;
      ST_ACCUM:    cmd.accum = 1'b1;
      ST_FINISH:   cmd.pos_start = status.pos_needed;
      ST_POS_DIV:  ;
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load   = 1'b1;
          cmd.finish     = !status.is_cal_result;
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== sv/calibrated_line_position_estimator.sv =====
// channel  signals                                   role
// in       in_valid, in_stall, in_item               samples and commands
// out      out_valid, out_stall, out_item            positions and thresholds
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data register writes
// A measure sample on a valid channel with unequal min and max runs the
// 26-step normalize divider; the last sample of a scan with a line found
// also runs the position divide. Reset is synchronous, active high.
// A result waits in the output register while out_stall is high; input stalls
// until the block is back in idle.
module calibrated_line_position_estimator #(
  parameter int NUM_CHANNELS = clpe_pkg::DEF_NUM_CHANNELS,
  parameter int SAMPLE_MAX   = clpe_pkg::DEF_SAMPLE_MAX,
  parameter int FULL_SCALE   = clpe_pkg::DEF_FULL_SCALE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  clpe_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output clpe_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [clpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clpe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import clpe_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  clpe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  clpe_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SAMPLE_MAX   (SAMPLE_MAX),
    .FULL_SCALE   (FULL_SCALE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );
endmodule

// ===== sv/clpe_checker.sv =====
module clpe_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input clpe_pkg::out_item_t out_item,
  input logic                out_valid,
  input logic                out_stall
);
  import clpe_pkg::*;

  // a held result must not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // accepting a request makes the block busy next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken without a gap");

  // threshold results carry no position
  a_thr_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == KIND_THRESHOLD |-> out_item.position == '0)
    else $error("threshold result carries position");

  // a found line's position stays within the array span
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == KIND_POSITION |->
      out_item.position <= 13'd7000 || !out_item.line_found)
    else $error("position out of range");
endmodule

bind calibrated_line_position_estimator clpe_checker u_clpe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_item  (out_item),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import clpe_pkg::*;

  localparam int NCH = 8;
  localparam int RIGHT_END = (NCH - 1) * 1000;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned idle_pct = 30;
  bit hold_rx = 1'b0;
  bit timed_out = 1'b0;
  int unsigned quiet_cycles = 0;

  always #5 clk = ~clk;

  calibrated_line_position_estimator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  class line_scoreboard;
    logic [11:0] lo_cal[NCH];
    logic [11:0] hi_cal[NCH];
    logic [25:0] wsum;
    logic [12:0] vsum;
    bit seen;
    logic [12:0] prev_pos;
    logic [9:0] detect_lvl, contrib_lvl;
    logic [12:0] left_lim, right_lim;
    out_item_t pending[$];
    int errors;

    function new();
      for (int i = 0; i < NCH; i++) begin
        lo_cal[i] = 12'd500;
        hi_cal[i] = 12'd3500;
      end
      wsum = '0;
      vsum = '0;
      seen = 0;
      prev_pos = 13'd3500;
      detect_lvl = 10'd200;
      contrib_lvl = 10'd50;
      left_lim = 13'd2000;
      right_lim = 13'd5000;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_LINE_DETECT: detect_lvl = val[9:0];
        REG_CONTRIBUTE: contrib_lvl = val[9:0];
        REG_LOST_LEFT: left_lim = val;
        REG_LOST_RIGHT: right_lim = val;
        default: ;
      endcase
    endfunction

    function longint norm_level(longint s, longint lo, longint hi);
      longint v;
      if (hi == lo) return 0;
      v = ((s - lo) * 1000) / (hi - lo);
      if (v < 0) v = 0;
      if (v > 1000) v = 1000;
      return v;
    endfunction

    function void note_request(in_item_t it);
      out_item_t r;
      longint v, w, t, p;
      int ch;
      ch = it.channel;
      r = '0;
      if (it.action == ACT_CLEAR) begin
        for (int i = 0; i < NCH; i++) begin
          lo_cal[i] = 12'd4095;
          hi_cal[i] = 12'd0;
        end
        return;
      end
      if (it.action == ACT_CALIBRATE) begin
        if (it.sample > hi_cal[ch]) hi_cal[ch] = it.sample;
        if (it.sample < lo_cal[ch]) lo_cal[ch] = it.sample;
        r.kind = KIND_THRESHOLD;
        r.threshold = 12'((int'(lo_cal[ch]) + int'(hi_cal[ch])) / 2);
        r.channel_out = it.channel;
        pending.push_back(r);
        return;
      end
      if (it.action != ACT_MEASURE) return;
      v = norm_level(it.sample, lo_cal[ch], hi_cal[ch]);
      if (v > detect_lvl) seen = 1;
      if (v > contrib_lvl) begin
        w = longint'(wsum) + v * ch * 1000;
        t = longint'(vsum) + v;
        wsum = (w > 67108863) ? 26'h3FFFFFF : 26'(w);
        vsum = (t > 8191) ? 13'h1FFF : 13'(t);
      end
      if (!it.last) return;
      r.kind = KIND_POSITION;
      if (!seen || vsum == 0) begin
        r.line_found = 1'b0;
        if (prev_pos < left_lim) p = 0;
        else if (prev_pos > right_lim) p = RIGHT_END;
        else p = prev_pos;
      end else begin
        r.line_found = 1'b1;
        p = longint'(wsum) / longint'(vsum);
        if (p > RIGHT_END) p = RIGHT_END;
        prev_pos = 13'(p);
      end
      r.position = 13'(p);
      wsum = '0;
      vsum = '0;
      seen = 0;
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.kind !== exp_r.kind)
        $display("%0t: kind expected %0d actual %0d", $realtime, exp_r.kind, got.kind);
      if (got.position !== exp_r.position)
        $display("%0t: position expected %0d actual %0d", $realtime,
                 exp_r.position, got.position);
      if (got.line_found !== exp_r.line_found)
        $display("%0t: line_found expected %0d actual %0d", $realtime,
                 exp_r.line_found, got.line_found);
      if (got.threshold !== exp_r.threshold)
        $display("%0t: threshold expected %0d actual %0d", $realtime,
                 exp_r.threshold, got.threshold);
      if (got.channel_out !== exp_r.channel_out)
        $display("%0t: channel_out expected %0d actual %0d", $realtime,
                 exp_r.channel_out, got.channel_out);
      if (got !== exp_r) errors++;
    endfunction
  endclass

  line_scoreboard board = new();

  // Sample both handshakes at the edge, before the drivers update.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note_request(in_item);
      if (out_valid && !out_stall) board.check_result(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
          || board.pending.size() == 0 && !in_valid)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || hold_rx) out_stall <= hold_rx;
    else out_stall <= ($urandom_range(99) < idle_pct);
  end

  // Valid stays up after an accepted request; drain() or an idle gap in the next send drops it.
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send(logic [1:0] act, int ch, int s, bit lst);
    in_item_t it;
    it.action = act;
    it.channel = 3'(ch);
    it.sample = 12'(s);
    it.last = lst;
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, CFG_DATA_W'(val));
  endtask

  task automatic set_levels(int det, int con, int lft, int rgt);
    drain();
    write_reg(REG_LINE_DETECT, det);
    write_reg(REG_CONTRIBUTE, con);
    write_reg(REG_LOST_LEFT, lft);
    write_reg(REG_LOST_RIGHT, rgt);
    cfg_valid <= 1'b0;
  endtask

  // Mostly full scans over all channels, with some calibration and noise.
  task automatic random_phase(int n);
    int k;
    k = 0;
    while (k < n) begin
      int r;
      r = $urandom_range(99);
      if (r < 70) begin
        for (int c = 0; c < NCH; c++)
          send(ACT_MEASURE, c, $urandom_range(4095), c == NCH - 1);
        k += NCH;
      end else if (r < 88) begin
        send(ACT_CALIBRATE, $urandom_range(7), $urandom_range(4095), $urandom_range(1));
        k++;
      end else if (r < 91) begin
        send(ACT_CLEAR, $urandom_range(7), $urandom_range(4095), $urandom_range(1));
        k++;
      end else begin
        send(2'($urandom_range(3)), $urandom_range(7), $urandom_range(4095),
             $urandom_range(1));
        k++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Defaults from reset first: lost line with previous mid position.
    send(ACT_MEASURE, 0, 0, 1'b1);
    send(ACT_MEASURE, 3, 4095, 1'b0);
    send(ACT_MEASURE, 4, 2000, 1'b1);
    send(2'd3, 7, 4095, 1'b1);
    send(ACT_CALIBRATE, 0, 0, 1'b0);
    send(ACT_CALIBRATE, 0, 4095, 1'b1);
    send(ACT_CLEAR, 0, 0, 1'b0);
    // After a clear, max below min: signed formula.
    send(ACT_MEASURE, 2, 3000, 1'b1);
    send(ACT_CALIBRATE, 5, 1234, 1'b0);
    // Equal min and max normalizes to zero.
    send(ACT_MEASURE, 5, 1234, 1'b1);
    for (int i = 0; i < NCH; i++) send(ACT_CALIBRATE, i, 100, 1'b0);
    for (int i = 0; i < NCH; i++) send(ACT_CALIBRATE, i, 4000, 1'b0);
    // Repeated channel to push the sums up.
    for (int i = 0; i < 12; i++) send(ACT_MEASURE, 7, 4095, i == 11);

    set_levels(0, 0, 0, 0);
    for (int c = 0; c < NCH; c++) send(ACT_MEASURE, c, 0, c == NCH - 1);
    set_levels(1000, 1000, 7000, 7000);
    random_phase(40);
    set_levels(1023, 1023, 8191, 8191);
    random_phase(40);
    set_levels(200, 50, 2000, 5000);

    // Hold the receiver off while the sender keeps going.
    hold_rx = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_rx = 1'b0;
      end
      random_phase(24);
    join
    drain();

    idle_pct = 0;
    random_phase(200);
    idle_pct = 30;
    random_phase(300);
    set_levels($urandom_range(1000), $urandom_range(1000), $urandom_range(7000),
               $urandom_range(7000));
    random_phase(400);

    drain();
    if (board.errors == 0 && board.pending.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/clpe_pkg.sv
sv/clpe_divider.sv
sv/clpe_datapath.sv
sv/clpe_ctrl.sv
sv/calibrated_line_position_estimator.sv
sv/clpe_checker.sv
test/testbench.sv
